// ----- rtl/backlight_step_dimming_pulser_assert.svh -----
// Assertion macros used by the step dimming pulser controller RTL.
`ifndef BACKLIGHT_STEP_DIMMING_PULSER_ASSERT_SVH
`define BACKLIGHT_STEP_DIMMING_PULSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BSDP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsdp assertion failed");

// Next-cycle implication, checked outside reset.
`define BSDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsdp assertion failed");

`endif

// ----- rtl/bsdp_pkg.sv -----
// Shared types and constants of the step dimming pulser.
`default_nettype none

package bsdp_pkg;

    localparam int unsigned LEVEL_W      = 5;
    localparam int unsigned TIME_W       = 10;
    localparam int unsigned REQ_W        = 8;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned MAX_LEVEL    = 17;
    localparam int unsigned ENABLE_LEVEL = 16;
    localparam int unsigned MAX_RESULTS  = 16;
    localparam int unsigned CNT_W        = $clog2(MAX_RESULTS + 1);

    localparam logic [LEVEL_W-1:0] LEVEL_RESET   = LEVEL_W'(6);
    localparam logic [TIME_W-1:0]  UP_LOW_RST    = TIME_W'(10);
    localparam logic [TIME_W-1:0]  UP_GAP_RST    = TIME_W'(3);
    localparam logic [TIME_W-1:0]  DOWN_LOW_RST  = TIME_W'(200);
    localparam logic [TIME_W-1:0]  DOWN_GAP_RST  = TIME_W'(30);
    localparam logic [TIME_W-1:0]  OFF_HOLD_RST  = TIME_W'(800);
    localparam logic [TIME_W-1:0]  EN_GAP_RST    = TIME_W'(5);

    // Pin action codes
    typedef enum logic [1:0] {
        ACT_LOW   = 2'd0,
        ACT_RAISE = 2'd1,
        ACT_UP    = 2'd2,
        ACT_DOWN  = 2'd3
    } t_action;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UP_LOW   = 3'd0,
        CFG_UP_GAP   = 3'd1,
        CFG_DOWN_LOW = 3'd2,
        CFG_DOWN_GAP = 3'd3,
        CFG_OFF_HOLD = 3'd4,
        CFG_EN_GAP   = 3'd5
    } t_cfg_idx;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // take the request beat and plan the run
        logic issue;  // move the next action into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pending;  // at least one action is still to be issued
        logic last;     // the next action is the final one of the run
    } t_status;

endpackage

`default_nettype wire

// ----- rtl/backlight_step_dimming_pulser.sv -----
// Top level of the single-wire step dimming backlight pulser.
//
// Input channel: one beat is one brightness request (level_request,
// panel_powered), taken when i_in_valid is high and o_in_stall is low.
// Output channel: one beat is one pin action with its low and high times;
// last_action marks the final beat of a request. A request yields 0 to 16
// beats (an unchanged level after no raise yields none).
// Sequence: a taken request is first planned into the run registers, and
// the run then issues one beat per cycle from them into the output
// register while the receiver takes them; the next request is taken once
// the last beat has been issued, even while that beat still waits at the
// output register.
// Stall: while i_out_stall is high the output register holds its beat and
// the run pauses; no beat is lost or repeated.
// Reset (synchronous, active low): timing registers return to their reset
// values, the applied level to 6, and any run in flight is dropped.
// Configuration: writes on i_cfg_we take effect at once; write only while
// no request is in progress.
`default_nettype none

module backlight_step_dimming_pulser (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [bsdp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [bsdp_pkg::TIME_W-1:0]      i_cfg_data,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire [bsdp_pkg::REQ_W-1:0]       i_level_request,
    input  wire                             i_panel_powered,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [1:0]                      o_pin_action,
    output logic [bsdp_pkg::TIME_W-1:0]     o_low_time,
    output logic [bsdp_pkg::TIME_W-1:0]     o_high_time,
    output logic                            o_last_action
);
    import bsdp_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequence the run
    bsdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Plan and produce the pin actions
    bsdp_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_level_request (i_level_request),
        .i_panel_powered (i_panel_powered),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_pin_action    (o_pin_action),
        .o_low_time      (o_low_time),
        .o_high_time     (o_high_time),
        .o_last_action   (o_last_action)
    );

endmodule

`default_nettype wire

// ----- rtl/bsdp_ctrl.sv -----
// Controller: request handshake, run sequencing and output valid.
`default_nettype none

`include "backlight_step_dimming_pulser_assert.svh"

module bsdp_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    input  bsdp_pkg::t_status  i_status,
    output bsdp_pkg::t_cmd     o_cmd
);
    import bsdp_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    // Decode commands
    always_comb begin
        slot_free   = !r_out_valid || !i_out_stall;
        o_cmd.load  = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.issue = (r_state == ST_RUN) && slot_free && i_status.pending;
    end

    // Advance the sequence and the output valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = o_cmd.issue || (r_out_valid && i_out_stall);
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.load) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!i_status.pending || (o_cmd.issue && i_status.last)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    `BSDP_ASSERT_NOW(a_issue_has_work, i_clk, i_rst_n, o_cmd.issue, i_status.pending)
    `BSDP_ASSERT_NOW(a_issue_has_slot, i_clk, i_rst_n, o_cmd.issue, slot_free)
    `BSDP_ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, o_cmd.issue && i_status.last,
        r_state == ST_IDLE)
    `BSDP_ASSERT_NEXT(a_load_starts_run, i_clk, i_rst_n, o_cmd.load, r_state == ST_RUN)

endmodule

`default_nettype wire

// ----- rtl/bsdp_datapath.sv -----
// Datapath: timing registers, applied level, run planning and output register.
`default_nettype none

module bsdp_datapath (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [bsdp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [bsdp_pkg::TIME_W-1:0]      i_cfg_data,
    input  wire  [bsdp_pkg::REQ_W-1:0]       i_level_request,
    input  wire                              i_panel_powered,
    input  bsdp_pkg::t_cmd                   i_cmd,
    output bsdp_pkg::t_status                o_status,
    output logic [1:0]                       o_pin_action,
    output logic [bsdp_pkg::TIME_W-1:0]      o_low_time,
    output logic [bsdp_pkg::TIME_W-1:0]      o_high_time,
    output logic                             o_last_action
);
    import bsdp_pkg::*;

    // Timing registers
    logic [TIME_W-1:0] r_up_low, r_up_gap, r_down_low, r_down_gap, r_off_hold, r_en_gap;
    // Level state and run plan
    logic [LEVEL_W-1:0] r_level;
    logic               r_single;    // one hold-low action
    logic               r_off;       // hold-low uses the off time
    logic               r_raise;     // raise action still to go
    logic               r_up;        // step direction
    logic [CNT_W-1:0]   r_steps;     // step pulses still to go
    // Output register
    t_action            r_act;
    logic [TIME_W-1:0]  r_low, r_high;
    logic               r_last;

    logic [LEVEL_W-1:0] req_sat, cur_eff, diff, n_level_plan;
    logic [CNT_W-1:0]   room, cnt;
    logic               go_raise, go_up;

    // Plan the run for the request beat
    always_comb begin
        if (i_level_request > REQ_W'(MAX_LEVEL)) begin
            req_sat = LEVEL_W'(MAX_LEVEL);
        end else begin
            req_sat = i_level_request[LEVEL_W-1:0];
        end
        go_raise = (r_level == '0);
        cur_eff  = go_raise ? LEVEL_W'(ENABLE_LEVEL) : r_level;
        room     = go_raise ? CNT_W'(MAX_RESULTS - 1) : CNT_W'(MAX_RESULTS);
        go_up    = (req_sat > cur_eff);
        diff     = go_up ? (req_sat - cur_eff) : (cur_eff - req_sat);
        if (CNT_W'(diff) > room) begin
            cnt = room;
        end else begin
            cnt = CNT_W'(diff);
        end
        if (go_up) begin
            n_level_plan = cur_eff + LEVEL_W'(cnt);
        end else begin
            n_level_plan = cur_eff - LEVEL_W'(cnt);
        end
    end

    // Hold timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_low   <= UP_LOW_RST;
            r_up_gap   <= UP_GAP_RST;
            r_down_low <= DOWN_LOW_RST;
            r_down_gap <= DOWN_GAP_RST;
            r_off_hold <= OFF_HOLD_RST;
            r_en_gap   <= EN_GAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_UP_LOW:   r_up_low   <= i_cfg_data;
                CFG_UP_GAP:   r_up_gap   <= i_cfg_data;
                CFG_DOWN_LOW: r_down_low <= i_cfg_data;
                CFG_DOWN_GAP: r_down_gap <= i_cfg_data;
                CFG_OFF_HOLD: r_off_hold <= i_cfg_data;
                CFG_EN_GAP:   r_en_gap   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Load the plan, then drain it one action per issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= LEVEL_RESET;
            r_single <= 1'b0;
            r_off    <= 1'b0;
            r_raise  <= 1'b0;
            r_up     <= 1'b0;
            r_steps  <= '0;
        end else if (i_cmd.load) begin
            r_up <= go_up;
            if (!i_panel_powered) begin
                r_single <= 1'b1;
                r_off    <= 1'b0;
                r_raise  <= 1'b0;
                r_steps  <= '0;
            end else if (req_sat == '0) begin
                r_single <= 1'b1;
                r_off    <= 1'b1;
                r_raise  <= 1'b0;
                r_steps  <= '0;
                r_level  <= '0;
            end else begin
                r_single <= 1'b0;
                r_off    <= 1'b0;
                r_raise  <= go_raise;
                r_steps  <= cnt;
                r_level  <= n_level_plan;
            end
        end else if (i_cmd.issue) begin
            if (r_single) begin
                r_single <= 1'b0;
            end else if (r_raise) begin
                r_raise <= 1'b0;
            end else begin
                r_steps <= r_steps - CNT_W'(1);
            end
        end
    end

    // Fill the output register on issue
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            if (r_single) begin
                r_act  <= ACT_LOW;
                r_low  <= r_off ? r_off_hold : '0;
                r_high <= '0;
                r_last <= 1'b1;
            end else if (r_raise) begin
                r_act  <= ACT_RAISE;
                r_low  <= '0;
                r_high <= r_en_gap;
                r_last <= (r_steps == '0);
            end else if (r_up) begin
                r_act  <= ACT_UP;
                r_low  <= r_up_low;
                r_high <= r_up_gap;
                r_last <= (r_steps == CNT_W'(1));
            end else begin
                r_act  <= ACT_DOWN;
                r_low  <= r_down_low;
                r_high <= r_down_gap;
                r_last <= (r_steps == CNT_W'(1));
            end
        end
    end

    // Report run progress
    always_comb begin
        o_status.pending = r_single || r_raise || (r_steps != '0);
        o_status.last    = r_single || (r_raise && (r_steps == '0))
                        || (!r_raise && (r_steps == CNT_W'(1)));
    end

    assign o_pin_action  = r_act;
    assign o_low_time    = r_low;
    assign o_high_time   = r_high;
    assign o_last_action = r_last;

endmodule

`default_nettype wire
